>>> src/msm_pkg.sv
// shared types, codes and constants of the sample mixer
`timescale 1ns / 1ps

package msm_pkg;

  localparam int unsigned CHANNELS_DEF     = 8;
  localparam int unsigned SAMPLE_DEPTH_DEF = 65536;

  localparam int unsigned MIX_W = 19;

  // action codes
  localparam logic [2:0] ACT_LOAD   = 3'd0;
  localparam logic [2:0] ACT_START  = 3'd1;
  localparam logic [2:0] ACT_SETVOL = 3'd2;
  localparam logic [2:0] ACT_STOP   = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  channel;
    logic [15:0] address;
    logic [7:0]  sample_byte;
    logic [16:0] sample_length;
    logic [19:0] step;
    logic [6:0]  volume;
  } in_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix;
    logic [15:0]             handle;
    logic [7:0]              playing_mask;
  } out_t;

  // commands from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clr;
    logic acc;
  } mac_ctrl_t;

endpackage

>>> src/msm_smem.sv
// sample memory: one write port, one registered read port
`timescale 1ns / 1ps

module msm_smem import msm_pkg::*; #(
  parameter int unsigned DEPTH = SAMPLE_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/msm_mac.sv
// shared multiply-accumulate unit with saturating mix accumulator
`timescale 1ns / 1ps

module msm_mac import msm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  logic [7:0]              sample_i,
  input  logic [6:0]              gain_i,
  output logic signed [MIX_W-1:0] sum_o
);

  localparam logic signed [MIX_W:0] SUM_MAX = (MIX_W + 1)'(262143);
  localparam logic signed [MIX_W:0] SUM_MIN = -(MIX_W + 1)'(262144);

  logic signed [8:0]       centered;
  logic signed [7:0]       gain_s;
  logic signed [16:0]      prod;
  logic signed [17:0]      term;
  logic signed [MIX_W:0]   sum_ext;
  logic signed [MIX_W-1:0] sum_q, sum_d;

  // ((byte-128)*256*vol)>>7 is exactly 2*(byte-128)*vol
  always_comb begin
    centered = $signed({1'b0, sample_i}) - 9'sd128;
    gain_s   = $signed({1'b0, gain_i});
    prod     = centered * gain_s;
    term     = {prod, 1'b0};
    sum_ext  = {sum_q[MIX_W-1], sum_q} + {{(MIX_W - 17){term[17]}}, term};
    sum_d    = sum_q;
    if (ctrl_i.clr) begin
      sum_d = '0;
    end else if (ctrl_i.acc) begin
      priority if (sum_ext > SUM_MAX) begin
        sum_d = SUM_MAX[MIX_W-1:0];
      end else if (sum_ext < SUM_MIN) begin
        sum_d = SUM_MIN[MIX_W-1:0];
      end else begin
        sum_d = sum_ext[MIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

>>> src/multichannel_sample_mixer_top.sv
// top level: sequencer, channel registers, sample memory and mac unit
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid_i  in_ready_o  in_data_i   | item in
//  out     | out_valid_o out_ready_i out_data_o  | result out
//  cfg     | cfg_valid_i cfg_ready_o cfg_data_i  | enable write
//
//  load, start, set volume, stop, disabled tick: the result is registered after the exec and
//    done states, and the next transaction is taken once the block is back in idle
//  enabled tick: adds a check step per free or expiring channel and a check and a mac step per playing
//    channel, set by the single sample memory read port and the one mac unit
//  a new item is taken only in idle; a result still waiting holds the next one in done
//  reset clears control, active bits, handle counter and enable;
//    sample memory holds no reset value; SAMPLE_DEPTH must be a power of two (unchecked)
`timescale 1ns / 1ps

module multichannel_sample_mixer_top import msm_pkg::*; #(
  parameter int unsigned CHANNELS     = CHANNELS_DEF,
  parameter int unsigned SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_data_i
);

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);
  localparam int unsigned SW = (AW > 18) ? AW : 18;
  localparam int unsigned MW = (CHANNELS < 8) ? CHANNELS : 8;
  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MAC  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          state_q, state_d;
  in_t                 item_q;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                enable_q;
  logic [15:0]         next_handle_q;
  logic [15:0]         handle_q;
  logic                out_valid_q;
  out_t                out_q;

  logic [15:0]         base_q [CHANNELS];
  logic [16:0]         len_q  [CHANNELS];
  logic [19:0]         step_q [CHANNELS];
  logic [32:0]         pos_q  [CHANNELS];
  logic [6:0]          gain_q [CHANNELS];
  logic [CHANNELS-1:0] active_q;

  logic                ch_ok;
  logic [CW-1:0]       ch_idx;
  logic                start_ok;
  logic [16:0]         ipos;
  logic                expired;
  logic                last_ch;
  logic [SW-1:0]       rd_sum;
  logic [SW-1:0]       wr_ext;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                mem_we;
  logic [7:0]          mem_rdata;
  mac_ctrl_t           mac_ctrl;
  logic signed [MIX_W-1:0] mac_sum;
  logic                out_free;
  logic [7:0]          mask;

  assign ch_ok    = int'(item_q.channel) < CHANNELS;
  assign ch_idx   = CW'(item_q.channel);
  assign start_ok = (item_q.action == ACT_START) && enable_q && ch_ok;
  assign ipos     = pos_q[cnt_q][32:16];
  assign expired  = ipos >= len_q[cnt_q];
  assign last_ch  = cnt_q == LAST_CH;
  assign out_free = !out_valid_q || out_ready_i;

  // addresses wrap modulo the memory depth
  assign rd_sum  = SW'(base_q[cnt_q]) + SW'(ipos);
  assign rd_addr = rd_sum[AW-1:0];
  assign wr_ext  = SW'(item_q.address);
  assign wr_addr = wr_ext[AW-1:0];
  assign mem_we  = (state_q == S_EXEC) && (item_q.action == ACT_LOAD);

  assign mask = 8'(active_q[MW-1:0]);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    mac_ctrl.clr = 1'b0;
    mac_ctrl.acc = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        mac_ctrl.clr = 1'b1;
        cnt_d        = '0;
        if ((item_q.action == ACT_TICK) && enable_q) begin
          state_d = S_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CHK: begin
        if (active_q[cnt_q] && !expired) begin
          state_d = S_MAC;
        end else if (last_ch) begin
          state_d = S_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MAC: begin
        mac_ctrl.acc = 1'b1;
        if (last_ch) begin
          state_d = S_DONE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_CHK;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      enable_q      <= 1'b0;
      next_handle_q <= 16'd1;
      active_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i) begin
        enable_q <= cfg_data_i;
      end
      if (state_q == S_EXEC) begin
        if (start_ok) begin
          active_q[ch_idx] <= 1'b1;
          next_handle_q    <= (next_handle_q == 16'hFFFF) ? 16'd1 : next_handle_q + 16'd1;
        end
        if ((item_q.action == ACT_STOP) && ch_ok) begin
          active_q[ch_idx] <= 1'b0;
        end
      end
      // a channel whose position reached its length is freed
      if ((state_q == S_CHK) && active_q[cnt_q] && expired) begin
        active_q[cnt_q] <= 1'b0;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (state_q == S_EXEC) begin
      handle_q <= start_ok ? next_handle_q : 16'd0;
      if (start_ok) begin
        base_q[ch_idx] <= item_q.address;
        len_q[ch_idx]  <= item_q.sample_length;
        step_q[ch_idx] <= item_q.step;
        pos_q[ch_idx]  <= '0;
        gain_q[ch_idx] <= item_q.volume;
      end
      if ((item_q.action == ACT_SETVOL) && ch_ok) begin
        gain_q[ch_idx] <= item_q.volume;
      end
    end
    if (state_q == S_MAC) begin
      pos_q[cnt_q] <= pos_q[cnt_q] + 33'(step_q[cnt_q]);
    end
    if ((state_q == S_DONE) && out_free) begin
      out_q.mix          <= mac_sum;
      out_q.handle       <= handle_q;
      out_q.playing_mask <= mask;
    end
  end

  msm_smem #(
    .DEPTH (SAMPLE_DEPTH)
  ) u_smem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_addr),
    .wdata_i (item_q.sample_byte),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  msm_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (mem_rdata),
    .gain_i   (gain_q[cnt_q]),
    .sum_o    (mac_sum)
  );

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

>>> src/msm_chk.sv
// port-level checker for the sample mixer, bound to the top level
`timescale 1ns / 1ps

module msm_chk import msm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // block works on one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous transaction still in work");

  // a start result carries no mix
  a_start_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.handle != 16'd0) |-> out_data_o.mix == '0)
    else $error("nonzero handle with nonzero mix");

  // a granted handle means the started channel is playing
  a_start_playing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.handle != 16'd0) |-> out_data_o.playing_mask != 8'd0)
    else $error("start granted but no channel playing");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

endmodule

bind multichannel_sample_mixer_top msm_chk u_msm_chk (.*);

>>> bench/multichannel_sample_mixer_top_tb.sv
// testbench for the sample mixer: directed and random traffic checked against a local predictor
`timescale 1ns / 1ps

module multichannel_sample_mixer_top_tb;
  import msm_pkg::*;

  localparam int CHANNELS       = CHANNELS_DEF;
  localparam int MEM_DEPTH      = SAMPLE_DEPTH_DEF;
  localparam int MIX_MAX        = (1 << (MIX_W - 1)) - 1;
  localparam int MIX_MIN        = -(1 << (MIX_W - 1));
  localparam int RX_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HANDLE_STARTS  = 40;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_HALF, RX_SPARSE} rx_mode_e;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_data_i  = 1'b0;

  multichannel_sample_mixer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0]  sample_mem   [MEM_DEPTH];
  bit          sample_known [MEM_DEPTH];
  logic [15:0] chan_base    [CHANNELS];
  logic [16:0] chan_len     [CHANNELS];
  logic [19:0] chan_step    [CHANNELS];
  logic [32:0] chan_pos     [CHANNELS];
  logic [6:0]  chan_gain    [CHANNELS];
  bit          chan_on      [CHANNELS];
  logic [15:0] handle_next  = 16'd1;
  bit          mixer_enable = 1'b0;

  out_t expected_outputs[$];
  int   mismatch_count = 0;

  // sender and receiver pacing
  bit gaps_on       = 1'b1;
  int burst_left    = 0;
  bit rx_free       = 1'b0;
  int hold_requests = 0;
  int items_sent    = 0;

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      chan_base[c] = '0;
      chan_len[c]  = '0;
      chan_step[c] = '0;
      chan_pos[c]  = '0;
      chan_gain[c] = '0;
      chan_on[c]   = 1'b0;
    end
  end

  function automatic out_t mixer_predict(input in_t item);
    out_t        res;
    int          sum;
    int          smp;
    logic [16:0] ipos;
    logic [15:0] addr;
    res = '0;
    sum = 0;
    case (item.action)
      ACT_LOAD: begin
        sample_mem[item.address]   = item.sample_byte;
        sample_known[item.address] = 1'b1;
      end
      ACT_START: if (mixer_enable) begin
        chan_base[item.channel] = item.address;
        chan_len[item.channel]  = item.sample_length;
        chan_step[item.channel] = item.step;
        chan_pos[item.channel]  = '0;
        chan_gain[item.channel] = item.volume;
        chan_on[item.channel]   = 1'b1;
        res.handle  = handle_next;
        handle_next = (handle_next == 16'hFFFF) ? 16'd1 : handle_next + 16'd1;
      end
      ACT_SETVOL: chan_gain[item.channel] = item.volume;
      ACT_STOP:   chan_on[item.channel] = 1'b0;
      ACT_TICK: if (mixer_enable) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (chan_on[c]) begin
            ipos = chan_pos[c][32:16];
            if (ipos >= chan_len[c]) begin
              chan_on[c] = 1'b0;
            end else begin
              addr = chan_base[c] + ipos[15:0];
              smp  = (int'(sample_mem[addr]) - 128) * 256;
              // arithmetic shift floors toward minus infinity
              sum += (smp * int'(chan_gain[c])) >>> 7;
              if (sum > MIX_MAX) sum = MIX_MAX;
              else if (sum < MIX_MIN) sum = MIX_MIN;
              chan_pos[c] = chan_pos[c] + chan_step[c];
            end
          end
        end
        res.mix = sum[MIX_W-1:0];
      end
      default: ;
    endcase
    for (int c = 0; c < CHANNELS; c++) res.playing_mask[c] = chan_on[c];
    return res;
  endfunction

  function automatic in_t random_fields();
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    return in_t'(rnd[$bits(in_t)-1:0]);
  endfunction

  function automatic in_t item_of(logic [2:0] act, logic [2:0] ch, logic [15:0] addr,
                                  logic [7:0] smp, logic [16:0] len, logic [19:0] stp,
                                  logic [6:0] vol);
    in_t it;
    it.action        = act;
    it.channel       = ch;
    it.address       = addr;
    it.sample_byte   = smp;
    it.sample_length = len;
    it.step          = stp;
    it.volume        = vol;
    return it;
  endfunction

  task automatic send_item(input in_t item);
    int gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 16);
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_outputs.push_back(mixer_predict(item));
    items_sent++;
  endtask

  // make sure every byte the next tick reads has been written
  task automatic preload_tick_reads();
    logic [16:0] ipos;
    logic [15:0] addr;
    in_t         ld;
    if (!mixer_enable) return;
    for (int c = 0; c < CHANNELS; c++) begin
      ipos = chan_pos[c][32:16];
      addr = chan_base[c] + ipos[15:0];
      if (chan_on[c] && ipos < chan_len[c] && !sample_known[addr]) begin
        ld         = random_fields();
        ld.action  = ACT_LOAD;
        ld.address = addr;
        send_item(ld);
      end
    end
  endtask

  task automatic issue(input in_t item);
    if (item.action == ACT_TICK) preload_tick_reads();
    send_item(item);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_enable(input bit value);
    wait_drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i  <= 1'b0;
    mixer_enable = value;
  endtask

  // out of reset the block is disabled: starts refused, ticks silent
  task automatic test_disabled_block();
    issue(item_of(ACT_LOAD, 3'd0, 16'h1234, 8'h5A, '0, '0, '0));
    issue(item_of(ACT_START, 3'd1, 16'h1234, 8'h00, 17'd4, 20'h10000, 7'd100));
    issue(item_of(ACT_TICK, 3'd0, '0, '0, '0, '0, '0));
    issue(item_of(ACT_SETVOL, 3'd6, '0, '0, '0, '0, 7'd127));
    issue(item_of(ACT_STOP, 3'd1, '0, '0, '0, '0, '0));
    issue(item_of(3'd5, 3'd2, 16'hFFFF, 8'hFF, '1, '1, '1));
  endtask

  task automatic test_directed_playback();
    issue(item_of(ACT_LOAD, 3'd0, 16'hFFFF, 8'hFF, '0, '0, '0));
    issue(item_of(ACT_LOAD, 3'd0, 16'h0000, 8'h00, '0, '0, '0));
    issue(item_of(ACT_LOAD, 3'd0, 16'h0001, 8'h80, '0, '0, '0));
    // plays across the top of memory back to address 0
    issue(item_of(ACT_START, 3'd0, 16'hFFFF, 8'h00, 17'd3, 20'h10000, 7'd127));
    // zero length, freed by the next tick
    issue(item_of(ACT_START, 3'd7, 16'h0000, 8'h00, 17'd0, 20'hFFFFF, 7'd127));
    issue(item_of(ACT_START, 3'd3, 16'h0001, 8'h00, 17'h10000, 20'h00000, 7'd0));
    issue(item_of(ACT_TICK, 3'd0, '0, '0, '0, '0, '0));
    issue(item_of(ACT_SETVOL, 3'd3, '0, '0, '0, '0, 7'd127));
    issue(item_of(ACT_TICK, 3'd0, '0, '0, '0, '0, '0));
    issue(item_of(ACT_SETVOL, 3'd5, '0, '0, '0, '0, 7'd100));
    issue(item_of(ACT_TICK, 3'd0, '0, '0, '0, '0, '0));
    issue(item_of(ACT_TICK, 3'd0, '0, '0, '0, '0, '0));
    issue(item_of(ACT_STOP, 3'd3, '0, '0, '0, '0, '0));
    issue(item_of(3'd7, 3'd7, '1, '1, '1, '1, '1));
  endtask

  task automatic test_disable_while_playing();
    issue(item_of(ACT_START, 3'd2, 16'hFFFF, 8'h00, 17'd4, 20'h04000, 7'd64));
    write_enable(1'b0);
    issue(item_of(ACT_TICK, 3'd0, '0, '0, '0, '0, '0));
    issue(item_of(ACT_START, 3'd4, 16'h0000, 8'h00, 17'd2, 20'h10000, 7'd10));
    write_enable(1'b1);
    issue(item_of(ACT_TICK, 3'd0, '0, '0, '0, '0, '0));
  endtask

  // n_items counts every transaction sent, the loads ahead of ticks too
  task automatic test_random_traffic(input int n_items);
    in_t it;
    int  pick;
    int  stop_at;
    int  round;
    stop_at = items_sent + n_items;
    round   = 0;
    while (items_sent < stop_at) begin
      if (round % 64 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      round++;
      it   = random_fields();
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        it.action = ACT_LOAD;
        if ($urandom_range(0, 2) != 0) it.address = 16'($urandom_range(0, 1100));
      end else if (pick < 45) begin
        it.action = ACT_START;
        case ($urandom_range(0, 3))
          0, 1:    it.address = 16'($urandom_range(0, 1023));
          2:       it.address = 16'($urandom_range(65472, 65535));
          default: ;
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: it.sample_length = 17'($urandom_range(0, 32));
          6, 7:             it.sample_length = 17'($urandom_range(33, 600));
          8:                it.sample_length = 17'h10000;
          default:          ;
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: it.step = 20'($urandom_range(32'h8000, 32'h20000));
          5:             it.step = '0;
          6:             it.step = '1;
          7:             it.step = 20'($urandom_range(0, 4096));
          default:       ;
        endcase
      end else if (pick < 80) begin
        it.action = ACT_TICK;
      end else if (pick < 87) begin
        it.action = ACT_SETVOL;
      end else if (pick < 94) begin
        it.action = ACT_STOP;
      end else begin
        it.action = 3'($urandom_range(5, 7));
      end
      issue(it);
    end
  endtask

  // receiver holds off while the sender keeps offering, then everything drains
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    hold_requests++;
    test_random_traffic(60);
    wait_drain();
    gaps_on = 1'b1;
  endtask

  // a run of granted starts, each handle one above the last
  task automatic test_handle_sequence();
    in_t it;
    write_enable(1'b1);
    gaps_on = 1'b0;
    rx_free = 1'b1;
    for (int i = 0; i < HANDLE_STARTS; i++) begin
      it               = random_fields();
      it.action        = ACT_START;
      it.sample_length = 17'($urandom_range(0, 16));
      issue(it);
    end
    wait_drain();
    rx_free = 1'b0;
    gaps_on = 1'b1;
  endtask

  // receiver stall pattern
  rx_mode_e rx_mode      = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_hold_left = 0;
  int       hold_served  = 0;

  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served  = hold_requests;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(5, 60);
    end else begin
      rx_mode_left--;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else if (rx_free) begin
      out_ready_i <= 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
        RX_HALF:   out_ready_i <= ($urandom_range(0, 1) != 0);
        default:   out_ready_i <= (rx_mode_left % 4 == 0);
      endcase
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_outputs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: mix %0d handle %0d mask %02h",
                   out_data_o.mix, out_data_o.handle, out_data_o.playing_mask);
      end else begin
        want = expected_outputs.pop_front();
        if (out_data_o.mix !== want.mix || out_data_o.handle !== want.handle ||
            out_data_o.playing_mask !== want.playing_mask) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: mix %0d/%0d handle %0d/%0d mask %02h/%02h (exp/got)",
                     want.mix, out_data_o.mix, want.handle, out_data_o.handle,
                     want.playing_mask, out_data_o.playing_mask);
        end
      end
    end
  end

  int stall_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled_block();
    write_enable(1'b1);
    test_directed_playback();
    test_disable_while_playing();
    test_random_traffic(250);
    write_enable(1'b0);
    test_random_traffic(60);
    write_enable(1'b1);
    test_random_traffic(150);
    test_output_backpressure();
    test_random_traffic(100);
    test_handle_sequence();
    test_random_traffic(150);
    wait_drain();
    repeat (40) @(posedge clk_i);
    if (expected_outputs.size() != 0) begin
      $display("%0d results never arrived", expected_outputs.size());
      mismatch_count += expected_outputs.size();
    end
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
